// ----- sv/fpr_pkg.sv -----
// Shared types, constants and the byte-wise CRC-32 function of the frame receiver.
package fpr_pkg;

	// Start-of-frame marker byte.
	localparam logic [7:0] FRAME_START = 8'hE7;

	// Reflected CRC-32 polynomial and seed.
	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

	// Configuration port sizes.
	localparam int CFG_IDX_W  = 3;
	localparam int SLOT_CODE_W = 9;
	localparam logic [SLOT_CODE_W-1:0] SLOT_UNUSED = 9'd256;

	// Result event codes.
	localparam logic [2:0] EV_NONE     = 3'd0;
	localparam logic [2:0] EV_OK_REG   = 3'd1;
	localparam logic [2:0] EV_OK_UNREG = 3'd2;
	localparam logic [2:0] EV_HDR_BAD  = 3'd3;
	localparam logic [2:0] EV_DATA_BAD = 3'd4;
	localparam logic [2:0] EV_READ     = 3'd5;

	// Input word as seen on the port.
	typedef struct packed {
		logic       cmd;
		logic [7:0] rx_byte;
		logic [7:0] read_index;
	} in_item_t;

	// Result word as driven on the port.
	typedef struct packed {
		logic [2:0] event_res;
		logic [7:0] frame_command;
		logic [7:0] payload_length;
		logic [2:0] matched_slot;
		logic [7:0] read_data;
	} out_item_t;

	// Classified word held in the queue between front and back.
	typedef struct packed {
		logic       is_read;
		logic       is_start;
		logic [7:0] rx_byte;
		logic       rd_ok;
		logic [7:0] rd_addr;
	} q_item_t;

	// Receiver modes, one-hot.
	typedef enum logic [5:0] {
		M_HUNT = 6'b000001,
		M_CMD  = 6'b000010,
		M_LEN  = 6'b000100,
		M_HCHK = 6'b001000,
		M_PAY  = 6'b010000,
		M_DCHK = 6'b100000
	} rx_mode_t;

	// Advances the reflected CRC-32 register by one byte.
	function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ----- sv/framed_packet_receiver_unit.sv -----
// Top level of the framed packet receiver: front end, queue, back end and configuration port.
//
// Usage: the in channel (in_valid/in_ready/in_data) carries one word per handshake. A word
// with cmd 0 is a line byte for the frame receiver, which hunts for 0xE7 and then takes the
// command, length, four header check bytes, the payload and four data check bytes, both
// checks being reflected CRC-32. A word with cmd 1 reads the payload buffer at read_index.
// Every input word gives exactly one result word on the out channel (out_valid/out_ready/
// out_data) carrying the event code, frame command and length, matched slot and read data.
// An accepted input word is written into the queue and then into the result register before
// its result is valid; throughput is one word per cycle while out_ready is high, set by the
// byte-wide CRC update and state step in the back end.
// A two-entry queue sits between the front end and the back end, and the back end owns a
// one-word result register, so a stalled receiver lets up to three words be held inside.
// When out_ready is low the result holds and the queue fills; in_ready drops once it is full.
// Reset clears the receiver to hunting, the CRC to all ones and every slot code to unused
// (256); the payload buffer is not cleared and needs no clearing pass. Slot codes are written
// through cfg_we/cfg_idx/cfg_wdata only while idle, a rule on the user the block does not enforce.
module framed_packet_receiver_unit #(
	parameter int PAYLOAD_DEPTH = 256,
	parameter int COMMAND_SLOTS = 6
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  fpr_pkg::in_item_t                in_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output fpr_pkg::out_item_t               out_data,
	input  logic                             cfg_we,
	input  logic [fpr_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [fpr_pkg::SLOT_CODE_W-1:0]  cfg_wdata
);

	logic             q_valid;
	logic             q_pop;
	fpr_pkg::q_item_t q_head;

	// Acceptance, classification and queue.
	fpr_front #(
		.PAYLOAD_DEPTH(PAYLOAD_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_valid  (q_valid),
		.q_head   (q_head),
		.q_pop    (q_pop)
	);

	// Frame processing and result delivery.
	fpr_back #(
		.PAYLOAD_DEPTH(PAYLOAD_DEPTH),
		.COMMAND_SLOTS(COMMAND_SLOTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ----- sv/fpr_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module fpr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port; the data register holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- sv/fpr_front.sv -----
// Front end: accepts input words, classifies them and queues them for the back end.
module fpr_front #(
	parameter int PAYLOAD_DEPTH = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  fpr_pkg::in_item_t in_data,
	output logic             q_valid,
	output fpr_pkg::q_item_t q_head,
	input  logic             q_pop
);

	localparam int QDEPTH = 2;

	fpr_pkg::q_item_t entry_q [QDEPTH];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             push;
	fpr_pkg::q_item_t cls;

	// Accept whenever the queue has a free entry.
	assign in_ready = (count_q != 2'(QDEPTH));
	assign push     = in_valid && in_ready;

	// Classify the incoming word.
	always_comb begin
		cls.is_read  = in_data.cmd;
		cls.is_start = (in_data.rx_byte == fpr_pkg::FRAME_START);
		cls.rx_byte  = in_data.rx_byte;
		cls.rd_ok    = ({1'b0, in_data.read_index} < 9'(PAYLOAD_DEPTH));
		cls.rd_addr  = in_data.read_index;
	end

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= cls;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !q_pop) begin
				count_q <= count_q + 2'd1;
			end else if (!push && q_pop) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	assign q_valid = (count_q != 2'd0);
	assign q_head  = entry_q[rd_ptr_q];

	// The fill count never passes the queue depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'(QDEPTH))
		else $error("queue count above depth");

	// The back end never pops an empty queue.
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (count_q != 2'd0))
		else $error("pop from empty queue");

	// With a free entry and a pending word, the word enters the queue.
	a_push_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !q_pop) |=> (count_q == $past(count_q) + 2'd1))
		else $error("push lost");

endmodule

// ----- sv/fpr_back.sv -----
// Back end: frame state machine, CRC checks, payload buffer, slot match and result register.
module fpr_back #(
	parameter int PAYLOAD_DEPTH = 256,
	parameter int COMMAND_SLOTS = 6
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               q_valid,
	input  fpr_pkg::q_item_t                   q_head,
	output logic                               q_pop,
	input  logic                               cfg_we,
	input  logic [fpr_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [fpr_pkg::SLOT_CODE_W-1:0]    cfg_wdata,
	output logic                               out_valid,
	input  logic                               out_ready,
	output fpr_pkg::out_item_t                 out_data
);

	localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;

	// Receiver state.
	fpr_pkg::rx_mode_t mode_q, mode_d;
	logic [7:0]  cmd_q, cmd_d;
	logic [7:0]  len_q, len_d;
	logic [7:0]  cnt_q, cnt_d;
	logic [1:0]  chk_cnt_q, chk_cnt_d;
	logic [31:0] rchk_q, rchk_d;
	logic [31:0] crc_q, crc_d;
	logic [fpr_pkg::SLOT_CODE_W-1:0] slot_q [COMMAND_SLOTS];

	// Result stage.
	logic        valid_s2;
	logic [2:0]  ev_s2;
	logic [7:0]  cmd_s2;
	logic [7:0]  len_s2;
	logic [2:0]  slot_s2;
	logic        rd_s2;

	logic        fire;
	logic [7:0]  b;
	logic [31:0] rchk_full;
	logic        last_chk;
	logic        crc_ok;
	logic        hit;
	logic [2:0]  hit_slot;
	logic [2:0]  ev;
	logic [2:0]  slot;
	logic [7:0]  cnt_inc;
	logic        ram_we;
	logic        ram_re;
	logic [7:0]  ram_rdata;

	// Take the queue head when the result register is free or draining.
	assign fire  = q_valid && (!valid_s2 || out_ready);
	assign q_pop = fire;
	assign b     = q_head.rx_byte;

	// Slot code registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < COMMAND_SLOTS; i++) begin
				slot_q[i] <= fpr_pkg::SLOT_UNUSED;
			end
		end else begin
			for (int i = 0; i < COMMAND_SLOTS; i++) begin
				if (cfg_we && (cfg_idx == fpr_pkg::CFG_IDX_W'(i))) begin
					slot_q[i] <= cfg_wdata;
				end
			end
		end
	end

	// Lowest slot whose code equals the frame command.
	always_comb begin
		hit      = 1'b0;
		hit_slot = 3'd0;
		for (int i = COMMAND_SLOTS - 1; i >= 0; i--) begin
			if (slot_q[i] == {1'b0, cmd_q}) begin
				hit      = 1'b1;
				hit_slot = 3'(i);
			end
		end
	end

	// Check-word assembly, little-endian.
	assign rchk_full = rchk_q | ({24'd0, b} << {chk_cnt_q, 3'b000});
	assign last_chk  = (chk_cnt_q == 2'd3);
	assign crc_ok    = (rchk_full == ~crc_q);
	assign cnt_inc   = cnt_q + 8'd1;

	// Next-state logic for one word.
	always_comb begin
		mode_d    = mode_q;
		cmd_d     = cmd_q;
		len_d     = len_q;
		cnt_d     = cnt_q;
		chk_cnt_d = chk_cnt_q;
		rchk_d    = rchk_q;
		crc_d     = crc_q;
		ev        = fpr_pkg::EV_NONE;
		slot      = 3'd0;
		if (q_head.is_read) begin
			ev = fpr_pkg::EV_READ;
		end else begin
			case (mode_q)
				fpr_pkg::M_CMD: begin
					cmd_d  = b;
					crc_d  = fpr_pkg::crc32_byte(crc_q, b);
					mode_d = fpr_pkg::M_LEN;
				end
				fpr_pkg::M_LEN: begin
					len_d     = b;
					crc_d     = fpr_pkg::crc32_byte(crc_q, b);
					chk_cnt_d = 2'd0;
					rchk_d    = 32'd0;
					mode_d    = fpr_pkg::M_HCHK;
				end
				fpr_pkg::M_HCHK: begin
					rchk_d    = rchk_full;
					chk_cnt_d = chk_cnt_q + 2'd1;
					if (last_chk) begin
						chk_cnt_d = 2'd0;
						if (crc_ok) begin
							cnt_d  = 8'd0;
							rchk_d = 32'd0;
							mode_d = (len_q == 8'd0) ? fpr_pkg::M_DCHK : fpr_pkg::M_PAY;
						end else begin
							ev     = fpr_pkg::EV_HDR_BAD;
							mode_d = fpr_pkg::M_HUNT;
						end
					end
				end
				fpr_pkg::M_PAY: begin
					crc_d = fpr_pkg::crc32_byte(crc_q, b);
					cnt_d = cnt_inc;
					if (cnt_inc == len_q) begin
						chk_cnt_d = 2'd0;
						rchk_d    = 32'd0;
						mode_d    = fpr_pkg::M_DCHK;
					end
				end
				fpr_pkg::M_DCHK: begin
					rchk_d    = rchk_full;
					chk_cnt_d = chk_cnt_q + 2'd1;
					if (last_chk) begin
						chk_cnt_d = 2'd0;
						if (crc_ok) begin
							ev   = hit ? fpr_pkg::EV_OK_REG : fpr_pkg::EV_OK_UNREG;
							slot = hit ? hit_slot : 3'd0;
						end else begin
							ev = fpr_pkg::EV_DATA_BAD;
						end
						mode_d = fpr_pkg::M_HUNT;
					end
				end
				default: begin
					// Hunting for the start byte.
					if (q_head.is_start) begin
						crc_d     = fpr_pkg::crc32_byte(fpr_pkg::CRC_INIT, b);
						cnt_d     = 8'd0;
						chk_cnt_d = 2'd0;
						rchk_d    = 32'd0;
						mode_d    = fpr_pkg::M_CMD;
					end else begin
						mode_d = fpr_pkg::M_HUNT;
					end
				end
			endcase
		end
	end

	// Receiver state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= fpr_pkg::M_HUNT;
			cmd_q     <= 8'd0;
			len_q     <= 8'd0;
			cnt_q     <= 8'd0;
			chk_cnt_q <= 2'd0;
			rchk_q    <= 32'd0;
			crc_q     <= fpr_pkg::CRC_INIT;
		end else if (fire) begin
			mode_q    <= mode_d;
			cmd_q     <= cmd_d;
			len_q     <= len_d;
			cnt_q     <= cnt_d;
			chk_cnt_q <= chk_cnt_d;
			rchk_q    <= rchk_d;
			crc_q     <= crc_d;
		end
	end

	// Payload buffer: bytes past its depth are counted but not stored.
	assign ram_we = fire && !q_head.is_read && (mode_q == fpr_pkg::M_PAY)
		&& ({1'b0, cnt_q} < 9'(PAYLOAD_DEPTH));
	assign ram_re = fire && q_head.is_read && q_head.rd_ok;

	fpr_ram #(
		.WIDTH(8),
		.DEPTH(PAYLOAD_DEPTH)
	) u_payload (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cnt_q[AW-1:0]),
		.wdata (b),
		.re    (ram_re),
		.raddr (q_head.rd_addr[AW-1:0]),
		.rdata (ram_rdata)
	);

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (fire) begin
			ev_s2   <= ev;
			cmd_s2  <= cmd_d;
			len_s2  <= len_d;
			slot_s2 <= slot;
			rd_s2   <= ram_re;
		end
	end

	assign out_valid               = valid_s2;
	assign out_data.event_res      = ev_s2;
	assign out_data.frame_command  = cmd_s2;
	assign out_data.payload_length = len_s2;
	assign out_data.matched_slot   = slot_s2;
	assign out_data.read_data      = rd_s2 ? ram_rdata : 8'd0;

	// Check bytes are only counted while a check word is being gathered.
	a_chk_cnt_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(chk_cnt_q != 2'd0) |-> (mode_q == fpr_pkg::M_HCHK || mode_q == fpr_pkg::M_DCHK))
		else $error("check byte count outside a check field");

	// Payload mode is only entered for a nonzero length.
	a_pay_len: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == fpr_pkg::M_PAY) |-> (len_q != 8'd0))
		else $error("payload mode with zero length");

	// A registered-frame result names a slot that exists.
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && ev_s2 == fpr_pkg::EV_OK_REG) |-> (slot_s2 < 3'(COMMAND_SLOTS)))
		else $error("matched slot out of range");

	// The buffer is never written and read by the same word.
	a_ram_port: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> !ram_re)
		else $error("payload buffer written and read together");

endmodule

// ----- tb/sv/framed_packet_receiver_unit_tb.sv -----
// Self-checking testbench for the framed packet receiver: directed table, random frames, reads.
module framed_packet_receiver_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_SLOT_REGS = 6;
	localparam int QUIET_LIMIT = 2000;
	localparam int MAX_REPORTS = 50;

	// How a table row turns into a line byte.
	typedef enum logic [1:0] {
		BYTE_AS_IS,
		BYTE_GOOD_CHECK,
		BYTE_BAD_CHECK
	} byte_fill_t;

	// One row of the directed table. For check rows, value holds the byte position 0 to 3.
	typedef struct packed {
		logic               cmd;
		logic [7:0]         value;
		logic [7:0]         index;
		byte_fill_t         fill;
		logic               pinned;
		fpr_pkg::out_item_t result;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	fpr_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	fpr_pkg::out_item_t out_data;
	logic cfg_we = 1'b0;
	logic [fpr_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
	logic [fpr_pkg::SLOT_CODE_W-1:0] cfg_wdata = '0;

	// Shadow copy of the receiver state and the slot registers.
	fpr_pkg::rx_mode_t rx_state = fpr_pkg::M_HUNT;
	logic [7:0] cur_cmd = 8'h00;
	logic [7:0] cur_len = 8'h00;
	logic [7:0] pay_cnt = 8'h00;
	logic [1:0] chk_cnt = 2'd0;
	logic [31:0] chk_word = 32'h0;
	logic [31:0] rx_crc = fpr_pkg::CRC_INIT;
	logic [7:0] payload_copy [256];
	int buf_hi = -1;
	logic [NUM_SLOT_REGS-1:0][fpr_pkg::SLOT_CODE_W-1:0] slot_codes =
		{NUM_SLOT_REGS{fpr_pkg::SLOT_UNUSED}};

	fpr_pkg::out_item_t pending_results [$];
	stim_row_t stim_table [$];
	int mismatch_count = 0;
	int rand_items = 0;
	int quiet_cycles = 0;
	int stall_left = 0;
	bit idle_on = 1'b1;

	framed_packet_receiver_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	// Reflected CRC-32, fed one data bit at a time.
	function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] d);
		logic [31:0] s;
		s = c;
		for (int k = 0; k < 8; k++)
			s = (s >> 1) ^ ((s[0] ^ d[k]) ? fpr_pkg::CRC_POLY : 32'd0);
		return s;
	endfunction

	function automatic fpr_pkg::out_item_t result_of(input logic [2:0] ev,
			input logic [7:0] c, input logic [7:0] n, input logic [2:0] s,
			input logic [7:0] d);
		fpr_pkg::out_item_t r;
		r.event_res = ev;
		r.frame_command = c;
		r.payload_length = n;
		r.matched_slot = s;
		r.read_data = d;
		return r;
	endfunction

	// Advances the shadow receiver by one word and gives the result it must produce.
	task automatic next_rx_result(input fpr_pkg::in_item_t w, output fpr_pkg::out_item_t r);
		logic [7:0] b;
		logic found;
		b = w.rx_byte;
		found = 1'b0;
		r = '0;
		if (w.cmd) begin
			r.event_res = fpr_pkg::EV_READ;
			r.read_data = payload_copy[w.read_index];
		end else begin
			case (rx_state)
				fpr_pkg::M_CMD: begin
					cur_cmd = b;
					rx_crc = crc_step(rx_crc, b);
					rx_state = fpr_pkg::M_LEN;
				end
				fpr_pkg::M_LEN: begin
					cur_len = b;
					rx_crc = crc_step(rx_crc, b);
					chk_cnt = 2'd0;
					chk_word = 32'h0;
					rx_state = fpr_pkg::M_HCHK;
				end
				fpr_pkg::M_PAY: begin
					payload_copy[pay_cnt] = b;
					if (int'(pay_cnt) > buf_hi)
						buf_hi = int'(pay_cnt);
					rx_crc = crc_step(rx_crc, b);
					pay_cnt = pay_cnt + 8'd1;
					if (pay_cnt == cur_len) begin
						chk_cnt = 2'd0;
						chk_word = 32'h0;
						rx_state = fpr_pkg::M_DCHK;
					end
				end
				fpr_pkg::M_HCHK, fpr_pkg::M_DCHK: begin
					// Check bytes arrive least significant first; the counter wraps after four.
					chk_word = chk_word | ({24'd0, b} << (8 * chk_cnt));
					chk_cnt = chk_cnt + 2'd1;
					if (chk_cnt == 2'd0) begin
						if (rx_state == fpr_pkg::M_HCHK) begin
							if (chk_word == ~rx_crc) begin
								pay_cnt = 8'h00;
								chk_word = 32'h0;
								rx_state = (cur_len == 8'h00) ? fpr_pkg::M_DCHK
									: fpr_pkg::M_PAY;
							end else begin
								r.event_res = fpr_pkg::EV_HDR_BAD;
								rx_state = fpr_pkg::M_HUNT;
							end
						end else begin
							if (chk_word == ~rx_crc) begin
								r.event_res = fpr_pkg::EV_OK_UNREG;
								// The lowest slot holding the command wins.
								for (int i = 0; i < NUM_SLOT_REGS; i++) begin
									if (!found && slot_codes[i] == {1'b0, cur_cmd}) begin
										found = 1'b1;
										r.event_res = fpr_pkg::EV_OK_REG;
										r.matched_slot = 3'(i);
									end
								end
							end else begin
								r.event_res = fpr_pkg::EV_DATA_BAD;
							end
							rx_state = fpr_pkg::M_HUNT;
						end
					end
				end
				default: begin
					if (b == fpr_pkg::FRAME_START) begin
						rx_crc = crc_step(fpr_pkg::CRC_INIT, b);
						pay_cnt = 8'h00;
						chk_cnt = 2'd0;
						chk_word = 32'h0;
						rx_state = fpr_pkg::M_CMD;
					end else begin
						rx_state = fpr_pkg::M_HUNT;
					end
				end
			endcase
		end
		r.frame_command = cur_cmd;
		r.payload_length = cur_len;
	endtask

	task automatic report_mismatch(input string what, input logic [7:0] got,
			input logic [7:0] want);
		if (mismatch_count < MAX_REPORTS)
			$display("mismatch on %s: got %0h, expected %0h at %0t", what, got, want, $time);
		mismatch_count++;
	endtask

	// Offers one word, waits for its handshake and records what it must produce.
	task automatic push_word(input fpr_pkg::in_item_t w, input logic pinned,
			input fpr_pkg::out_item_t pin);
		fpr_pkg::out_item_t want;
		if (idle_on && $urandom_range(0, 9) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		@(posedge clk);
		while (in_ready !== 1'b1) @(posedge clk);
		next_rx_result(w, want);
		pending_results.push_back(pinned ? pin : want);
		@(negedge clk);
	endtask

	// Sends a line byte, now and then preceded by a read of the written part of the buffer.
	task automatic send_line(input logic [7:0] b);
		fpr_pkg::in_item_t w;
		if (buf_hi >= 0 && $urandom_range(0, 9) == 0) begin
			w.cmd = 1'b1;
			w.rx_byte = 8'($urandom);
			w.read_index = 8'($urandom_range(0, buf_hi));
			push_word(w, 1'b0, '0);
			rand_items++;
		end
		w.cmd = 1'b0;
		w.rx_byte = b;
		w.read_index = 8'($urandom);
		push_word(w, 1'b0, '0);
		rand_items++;
	endtask

	// Four check bytes taken from the running CRC; a bad check spoils one of them.
	task automatic send_check(input bit good);
		logic [31:0] sum;
		logic [7:0] b;
		int bad_at;
		bad_at = good ? 4 : $urandom_range(0, 3);
		for (int k = 0; k < 4; k++) begin
			sum = ~rx_crc;
			b = sum[8 * k +: 8];
			if (k == bad_at)
				b ^= 8'($urandom_range(1, 255));
			send_line(b);
		end
	endtask

	// One frame with random content, sometimes after line noise and sometimes cut short.
	task automatic send_frame(input bit longest);
		logic [7:0] code;
		logic [7:0] len;
		fpr_pkg::in_item_t w;
		if ($urandom_range(0, 4) == 0) begin
			repeat ($urandom_range(1, 3)) begin
				w.cmd = 1'b0;
				w.rx_byte = 8'($urandom);
				w.read_index = 8'($urandom);
				push_word(w, 1'b0, '0);
			end
		end
		code = $urandom_range(0, 1) ? slot_codes[$urandom_range(0, NUM_SLOT_REGS - 1)][7:0]
			: 8'($urandom);
		if (longest)
			len = 8'd255;
		else if ($urandom_range(0, 7) == 0)
			len = 8'($urandom_range(7, 40));
		else
			len = 8'($urandom_range(0, 6));
		send_line(fpr_pkg::FRAME_START);
		send_line(code);
		send_line(len);
		send_check($urandom_range(0, 9) != 0);
		if ($urandom_range(0, 24) == 0)
			return;
		for (int k = 0; k < int'(len); k++)
			send_line(8'($urandom));
		send_check($urandom_range(0, 6) != 0);
	endtask

	// Writes every slot register; optionally also the indexes past the list, which must be ignored.
	task automatic load_slots(input logic [NUM_SLOT_REGS-1:0][fpr_pkg::SLOT_CODE_W-1:0] codes,
			input bit poke_spare);
		for (int i = 0; i < NUM_SLOT_REGS; i++) begin
			cfg_we <= 1'b1;
			cfg_idx <= fpr_pkg::CFG_IDX_W'(i);
			cfg_wdata <= codes[i];
			slot_codes[i] = codes[i];
			@(negedge clk);
		end
		if (poke_spare) begin
			for (int i = NUM_SLOT_REGS; i < 2 ** fpr_pkg::CFG_IDX_W; i++) begin
				cfg_idx <= fpr_pkg::CFG_IDX_W'(i);
				cfg_wdata <= 9'h055;
				@(negedge clk);
			end
		end
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Stops offering words and waits until every result has come back.
	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending_results.size() != 0) @(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic add_row(input logic c, input logic [7:0] v, input logic [7:0] ix,
			input byte_fill_t f, input logic p, input fpr_pkg::out_item_t e);
		stim_row_t row;
		row.cmd = c;
		row.value = v;
		row.index = ix;
		row.fill = f;
		row.pinned = p;
		row.result = e;
		stim_table.push_back(row);
	endtask

	// Receiver back-pressure in random bursts.
	always @(negedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 9) == 0) begin
			stall_left <= $urandom_range(0, 15);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Compares each accepted result word with the oldest pending expectation.
	always @(posedge clk) begin : result_check
		fpr_pkg::out_item_t want;
		if (out_valid === 1'b1 && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result word with nothing pending",
					8'(out_data.event_res), 8'(fpr_pkg::EV_NONE));
			end else begin
				want = pending_results.pop_front();
				if (out_data.event_res !== want.event_res)
					report_mismatch("event_res", 8'(out_data.event_res),
						8'(want.event_res));
				if (out_data.frame_command !== want.frame_command)
					report_mismatch("frame_command", out_data.frame_command,
						want.frame_command);
				if (out_data.payload_length !== want.payload_length)
					report_mismatch("payload_length", out_data.payload_length,
						want.payload_length);
				if (out_data.matched_slot !== want.matched_slot)
					report_mismatch("matched_slot", 8'(out_data.matched_slot),
						8'(want.matched_slot));
				if (out_data.read_data !== want.read_data)
					report_mismatch("read_data", out_data.read_data, want.read_data);
			end
		end
	end

	// Watchdog: too long without any handshake ends the run.
	always @(posedge clk) begin
		if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("framed_packet_receiver_unit_tb failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		logic [NUM_SLOT_REGS-1:0][fpr_pkg::SLOT_CODE_W-1:0] codes;
		stim_row_t row;
		fpr_pkg::in_item_t word;
		logic [31:0] check_word;

		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part: zero code, all-ones code, a duplicated code, unused and oversized codes.
		codes = {9'd511, fpr_pkg::SLOT_UNUSED, 9'h03C, 9'h03C, 9'h0FF, 9'h000};
		load_slots(codes, 1'b1);

		// Start byte right after reset, then a bad header check with the largest length.
		add_row(1'b0, fpr_pkg::FRAME_START, 8'h00, BYTE_AS_IS, 1'b1,
			result_of(fpr_pkg::EV_NONE, 8'h00, 8'h00, 3'd0, 8'h00));
		add_row(1'b0, 8'h80, 8'hFF, BYTE_AS_IS, 1'b0, '0);
		add_row(1'b0, 8'hFF, 8'h00, BYTE_AS_IS, 1'b0, '0);
		for (int k = 0; k < 4; k++)
			add_row(1'b0, 8'(k), 8'hFF, BYTE_BAD_CHECK, k == 3,
				result_of(fpr_pkg::EV_HDR_BAD, 8'h80, 8'hFF, 3'd0, 8'h00));
		// Zero length goes straight to the data check; the duplicate code picks slot 2.
		add_row(1'b0, fpr_pkg::FRAME_START, 8'h00, BYTE_AS_IS, 1'b0, '0);
		add_row(1'b0, 8'h3C, 8'h00, BYTE_AS_IS, 1'b0, '0);
		add_row(1'b0, 8'h00, 8'h00, BYTE_AS_IS, 1'b0, '0);
		for (int k = 0; k < 8; k++)
			add_row(1'b0, 8'(k % 4), 8'h00, BYTE_GOOD_CHECK, k == 7,
				result_of(fpr_pkg::EV_OK_REG, 8'h3C, 8'h00, 3'd2, 8'h00));
		// One payload byte, a read in the middle of the frame, then a spoiled data check.
		add_row(1'b0, fpr_pkg::FRAME_START, 8'h00, BYTE_AS_IS, 1'b0, '0);
		add_row(1'b0, 8'h00, 8'h00, BYTE_AS_IS, 1'b0, '0);
		add_row(1'b0, 8'h01, 8'h00, BYTE_AS_IS, 1'b0, '0);
		for (int k = 0; k < 4; k++)
			add_row(1'b0, 8'(k), 8'h00, BYTE_GOOD_CHECK, 1'b0, '0);
		add_row(1'b0, 8'hFF, 8'hFF, BYTE_AS_IS, 1'b0, '0);
		add_row(1'b1, 8'hA5, 8'h00, BYTE_AS_IS, 1'b1,
			result_of(fpr_pkg::EV_READ, 8'h00, 8'h01, 3'd0, 8'hFF));
		for (int k = 0; k < 4; k++)
			add_row(1'b0, 8'(k), 8'h00, k == 3 ? BYTE_BAD_CHECK : BYTE_GOOD_CHECK, k == 3,
				result_of(fpr_pkg::EV_DATA_BAD, 8'h00, 8'h01, 3'd0, 8'h00));

		foreach (stim_table[n]) begin
			row = stim_table[n];
			word.cmd = row.cmd;
			word.rx_byte = row.value;
			word.read_index = row.index;
			if (row.fill != BYTE_AS_IS) begin
				check_word = ~rx_crc;
				word.rx_byte = check_word[8 * row.value +: 8];
				if (row.fill == BYTE_BAD_CHECK)
					word.rx_byte ^= 8'h01;
			end
			push_word(word, row.pinned, row.result);
		end
		drain();

		// Random codes with some slots unused, and one frame of the largest size.
		for (int i = 0; i < NUM_SLOT_REGS; i++)
			codes[i] = ($urandom_range(0, 3) == 0) ? fpr_pkg::SLOT_UNUSED
				: 9'($urandom_range(0, 255));
		codes[NUM_SLOT_REGS - 1] = 9'd511;
		load_slots(codes, 1'b0);
		send_frame(1'b1);
		while (rand_items < 300) send_frame(1'b0);
		drain();

		// Every slot unused: good frames are never registered.
		codes = {NUM_SLOT_REGS{fpr_pkg::SLOT_UNUSED}};
		load_slots(codes, 1'b0);
		while (rand_items < 340) send_frame(1'b0);
		drain();

		// Codes with frequent duplicates; the tail of the run is free of idling.
		codes[0] = 9'($urandom_range(0, 255));
		for (int i = 1; i < NUM_SLOT_REGS; i++)
			codes[i] = ($urandom_range(0, 2) == 0) ? codes[i - 1] : 9'($urandom_range(0, 255));
		load_slots(codes, 1'b0);
		while (rand_items < 370) send_frame(1'b0);
		idle_on = 1'b0;
		while (rand_items < 410) send_frame(1'b0);
		drain();

		if (mismatch_count == 0)
			$display("framed_packet_receiver_unit_tb passed");
		else
			$display("framed_packet_receiver_unit_tb failed");
		$finish;
	end

endmodule
